// File: hw/rtl/morse_edge_timing_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Morse edge timing decoder assertion macros
// Assertion helpers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MORSE_EDGE_TIMING_DECODER_TOP_MACROS_SVH
`define MORSE_EDGE_TIMING_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define METD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define METD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define METD_ASSERT_IMP(label, ante, cons, msg)
`define METD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/metd_pkg.sv
// ----------------------------------------------------------------------------
// Morse edge timing decoder package
// Configuration layout, register indexes, reset values and the code table.
// ----------------------------------------------------------------------------
`default_nettype none

package metd_pkg;

	localparam int CFG_W       = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CHAR_W      = 7;
	localparam int EDGE_TIME_W = 32;
	localparam int CODE_MAX_LEN = 5;

	localparam logic [CFG_INDEX_W-1:0] CFG_DOT_LOW    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOT_HIGH   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DASH_LOW   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DASH_HIGH  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LETTER_GAP = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_WORD_GAP   = 3'd5;

	localparam logic [CFG_W-1:0] RST_DOT_LOW    = 32'd5000;
	localparam logic [CFG_W-1:0] RST_DOT_HIGH   = 32'd15000;
	localparam logic [CFG_W-1:0] RST_DASH_LOW   = 32'd25000;
	localparam logic [CFG_W-1:0] RST_DASH_HIGH  = 32'd35000;
	localparam logic [CFG_W-1:0] RST_LETTER_GAP = 32'd20000;
	localparam logic [CFG_W-1:0] RST_WORD_GAP   = 32'd60000;

	localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd63;
	localparam logic [CHAR_W-1:0] CHAR_A       = 7'd65;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;

	typedef struct packed {
		logic [CFG_W-1:0] dot_low;
		logic [CFG_W-1:0] dot_high;
		logic [CFG_W-1:0] dash_low;
		logic [CFG_W-1:0] dash_high;
		logic [CFG_W-1:0] letter_gap;
		logic [CFG_W-1:0] word_gap;
	} cfg_t;

	// Symbol k of a pattern sits at bit k, a dash is a one.
	function automatic logic [CHAR_W-1:0] code_to_char(input logic [2:0] len,
		input logic [4:0] pat);
		logic [CHAR_W-1:0] ch;
		unique case ({len, pat})
			{3'd2, 5'd2}:  ch = CHAR_A;
			{3'd4, 5'd1}:  ch = CHAR_A + 7'd1;
			{3'd4, 5'd5}:  ch = CHAR_A + 7'd2;
			{3'd3, 5'd1}:  ch = CHAR_A + 7'd3;
			{3'd1, 5'd0}:  ch = CHAR_A + 7'd4;
			{3'd4, 5'd4}:  ch = CHAR_A + 7'd5;
			{3'd3, 5'd3}:  ch = CHAR_A + 7'd6;
			{3'd4, 5'd0}:  ch = CHAR_A + 7'd7;
			{3'd2, 5'd0}:  ch = CHAR_A + 7'd8;
			{3'd4, 5'd14}: ch = CHAR_A + 7'd9;
			{3'd3, 5'd5}:  ch = CHAR_A + 7'd10;
			{3'd4, 5'd2}:  ch = CHAR_A + 7'd11;
			{3'd2, 5'd3}:  ch = CHAR_A + 7'd12;
			{3'd2, 5'd1}:  ch = CHAR_A + 7'd13;
			{3'd3, 5'd7}:  ch = CHAR_A + 7'd14;
			{3'd4, 5'd6}:  ch = CHAR_A + 7'd15;
			{3'd4, 5'd11}: ch = CHAR_A + 7'd16;
			{3'd3, 5'd2}:  ch = CHAR_A + 7'd17;
			{3'd3, 5'd0}:  ch = CHAR_A + 7'd18;
			{3'd1, 5'd1}:  ch = CHAR_A + 7'd19;
			{3'd3, 5'd4}:  ch = CHAR_A + 7'd20;
			{3'd4, 5'd8}:  ch = CHAR_A + 7'd21;
			{3'd3, 5'd6}:  ch = CHAR_A + 7'd22;
			{3'd4, 5'd9}:  ch = CHAR_A + 7'd23;
			{3'd4, 5'd13}: ch = CHAR_A + 7'd24;
			{3'd4, 5'd3}:  ch = CHAR_A + 7'd25;
			{3'd5, 5'd31}: ch = CHAR_ZERO;
			{3'd5, 5'd30}: ch = CHAR_ZERO + 7'd1;
			{3'd5, 5'd28}: ch = CHAR_ZERO + 7'd2;
			{3'd5, 5'd24}: ch = CHAR_ZERO + 7'd3;
			{3'd5, 5'd16}: ch = CHAR_ZERO + 7'd4;
			{3'd5, 5'd0}:  ch = CHAR_ZERO + 7'd5;
			{3'd5, 5'd1}:  ch = CHAR_ZERO + 7'd6;
			{3'd5, 5'd3}:  ch = CHAR_ZERO + 7'd7;
			{3'd5, 5'd7}:  ch = CHAR_ZERO + 7'd8;
			{3'd5, 5'd15}: ch = CHAR_ZERO + 7'd9;
			default:       ch = CHAR_UNKNOWN;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/metd_edge_if.sv
// ----------------------------------------------------------------------------
// Edge event channel
// Valid/ready channel carrying one timestamped edge per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface metd_edge_if;
	logic        valid;
	logic        ready;
	logic [31:0] edge_time;
	logic        edge_level;

	modport source (output valid, output edge_time, output edge_level, input ready);
	modport sink (input valid, input edge_time, input edge_level, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/metd_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one decoded character per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface metd_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic       word_end;

	modport source (output valid, output character, output word_end, input ready);
	modport sink (input valid, input character, input word_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/morse_edge_timing_decoder_top.sv
// ----------------------------------------------------------------------------
// Morse edge timing decoder
// Edge events in, decoded ASCII characters out.
//
// edge_in takes one edge per request: a microsecond timestamp and the new
// light level. char_out gives one request per finished letter: the ASCII
// code, or '?' for an unknown pattern, and a word-end flag. Most edges give
// no character. The cfg port writes the six timing thresholds; users must
// do so only while idle, as the block itself does not enforce this.
//
// An accepted edge waits in the input register; on advance its character
// is registered for char_out. One edge is accepted every cycle unless
// char_out stalls, set by the single input-to-result register stage. If
// char_out stalls holding a character, one more edge enters the input
// register, then edge_in.ready drops until it is taken. Reset empties both
// stages, clears the held pattern and edge history, and loads the defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "morse_edge_timing_decoder_top_macros.svh"

module morse_edge_timing_decoder_top
	import metd_pkg::*;
#(
	parameter int MAX_SYMBOLS = 9,
	parameter int TIME_BITS   = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	metd_edge_if.sink                   edge_in,
	metd_char_if.source                 char_out,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_wdata
);

	localparam int SW   = (TIME_BITS < EDGE_TIME_W) ? TIME_BITS : EDGE_TIME_W;
	localparam int CNTW = $clog2(MAX_SYMBOLS + 1);

	cfg_t                   cfg;
	logic                   valid_s1;
	logic [SW-1:0]          time_s1;
	logic                   level_s1;
	logic [SW-1:0]          rise_stamp_q;
	logic [SW-1:0]          fall_stamp_q;
	logic                   rise_seen_q;
	logic                   fall_seen_q;
	logic [MAX_SYMBOLS-1:0] sym_bits_q;
	logic [CNTW-1:0]        sym_count_q;
	logic                   res_valid_q;
	logic [CHAR_W-1:0]      res_char_q;
	logic                   res_word_q;
	logic [MAX_SYMBOLS-1:0] sym_bits_n;
	logic [CNTW-1:0]        sym_count_n;
	logic                   emit;
	logic [CHAR_W-1:0]      dec_char;
	logic                   dec_word;
	logic                   advance;
	logic                   in_fire;

	metd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	metd_decode #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.TIME_BITS   (TIME_BITS)
	) u_decode (
		.now         (time_s1),
		.rising      (level_s1),
		.rise_stamp  (rise_stamp_q),
		.fall_stamp  (fall_stamp_q),
		.rise_seen   (rise_seen_q),
		.fall_seen   (fall_seen_q),
		.sym_bits    (sym_bits_q),
		.sym_count   (sym_count_q),
		.cfg         (cfg),
		.sym_bits_n  (sym_bits_n),
		.sym_count_n (sym_count_n),
		.emit        (emit),
		.character   (dec_char),
		.word_end    (dec_word)
	);

	assign advance       = valid_s1 && (!res_valid_q || char_out.ready);
	assign edge_in.ready = !valid_s1 || advance;
	assign in_fire       = edge_in.valid && edge_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edge_in.ready) begin
			valid_s1 <= edge_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			time_s1  <= SW'(edge_in.edge_time);
			level_s1 <= edge_in.edge_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_stamp_q <= '0;
			fall_stamp_q <= '0;
			rise_seen_q  <= 1'b0;
			fall_seen_q  <= 1'b0;
			sym_bits_q   <= '0;
			sym_count_q  <= '0;
		end else if (advance) begin
			if (level_s1) begin
				rise_stamp_q <= time_s1;
				rise_seen_q  <= 1'b1;
			end else begin
				fall_stamp_q <= time_s1;
				fall_seen_q  <= 1'b1;
			end
			sym_bits_q  <= sym_bits_n;
			sym_count_q <= sym_count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (char_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_char_q <= dec_char;
			res_word_q <= dec_word;
		end
	end

	assign char_out.valid     = res_valid_q;
	assign char_out.character = res_char_q;
	assign char_out.word_end  = res_word_q;

	`METD_ASSERT_IMP(a_count_limit, 1'b1, sym_count_q <= CNTW'(MAX_SYMBOLS), "symbol count past limit")
	`METD_ASSERT_IMP(a_empty_pattern, sym_count_q == '0, sym_bits_q == '0, "bits held with no symbols")
	`METD_ASSERT_NXT(a_clear_on_emit, advance && emit, sym_count_q == '0 && res_valid_q, "pattern not cleared after character")
	`METD_ASSERT_IMP(a_fall_no_emit, valid_s1 && !level_s1, !emit, "falling edge produced a character")
	`METD_ASSERT_IMP(a_stall_only, !edge_in.ready, valid_s1 && res_valid_q && !char_out.ready, "input stalled without cause")

endmodule

`default_nettype wire

// File: hw/rtl/metd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the pulse windows and gap thresholds, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module metd_cfg_regs
	import metd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_low    <= RST_DOT_LOW;
			cfg_q.dot_high   <= RST_DOT_HIGH;
			cfg_q.dash_low   <= RST_DASH_LOW;
			cfg_q.dash_high  <= RST_DASH_HIGH;
			cfg_q.letter_gap <= RST_LETTER_GAP;
			cfg_q.word_gap   <= RST_WORD_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DOT_LOW:    cfg_q.dot_low    <= cfg_wdata;
				CFG_DOT_HIGH:   cfg_q.dot_high   <= cfg_wdata;
				CFG_DASH_LOW:   cfg_q.dash_low   <= cfg_wdata;
				CFG_DASH_HIGH:  cfg_q.dash_high  <= cfg_wdata;
				CFG_LETTER_GAP: cfg_q.letter_gap <= cfg_wdata;
				CFG_WORD_GAP:   cfg_q.word_gap   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/metd_decode.sv
// ----------------------------------------------------------------------------
// Edge decode datapath
// Measures the pulse or gap of one edge, updates the held pattern and
// looks up the character when a letter ends.
// ----------------------------------------------------------------------------
`default_nettype none

module metd_decode
	import metd_pkg::*;
#(
	parameter int MAX_SYMBOLS = 9,
	parameter int TIME_BITS   = 32,
	localparam int SW   = (TIME_BITS < EDGE_TIME_W) ? TIME_BITS : EDGE_TIME_W,
	localparam int CMPW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W,
	localparam int CNTW = $clog2(MAX_SYMBOLS + 1)
) (
	input  wire logic [SW-1:0]          now,
	input  wire logic                   rising,
	input  wire logic [SW-1:0]          rise_stamp,
	input  wire logic [SW-1:0]          fall_stamp,
	input  wire logic                   rise_seen,
	input  wire logic                   fall_seen,
	input  wire logic [MAX_SYMBOLS-1:0] sym_bits,
	input  wire logic [CNTW-1:0]        sym_count,
	input  wire cfg_t                   cfg,
	output logic [MAX_SYMBOLS-1:0]      sym_bits_n,
	output logic [CNTW-1:0]             sym_count_n,
	output logic                        emit,
	output logic [CHAR_W-1:0]           character,
	output logic                        word_end
);

	logic [TIME_BITS-1:0] pulse_t;
	logic [TIME_BITS-1:0] gap_t;
	logic [CMPW-1:0]      pulse;
	logic [CMPW-1:0]      gap;
	logic                 is_dash;
	logic                 is_dot;
	logic                 word_hit;
	logic                 letter_hit;
	logic                 room;

	assign pulse_t = TIME_BITS'(now) - TIME_BITS'(rise_stamp);
	assign gap_t   = TIME_BITS'(now) - TIME_BITS'(fall_stamp);
	assign pulse   = CMPW'(pulse_t);
	assign gap     = CMPW'(gap_t);

	assign is_dash = (pulse >= CMPW'(cfg.dash_low)) && (pulse <= CMPW'(cfg.dash_high));
	assign is_dot  = (pulse >= CMPW'(cfg.dot_low)) && (pulse <= CMPW'(cfg.dot_high));
	assign word_hit   = gap > CMPW'(cfg.word_gap);
	assign letter_hit = gap > CMPW'(cfg.letter_gap);
	assign room       = sym_count < CNTW'(MAX_SYMBOLS);

	always_comb begin
		sym_bits_n  = sym_bits;
		sym_count_n = sym_count;
		emit        = 1'b0;
		word_end    = word_hit;
		if (sym_count > CNTW'(CODE_MAX_LEN)) begin
			character = CHAR_UNKNOWN;
		end else begin
			character = code_to_char(sym_count[2:0], sym_bits[4:0]);
		end
		if (rising) begin
			if (fall_seen && (sym_count != '0) && (word_hit || letter_hit)) begin
				emit        = 1'b1;
				sym_bits_n  = '0;
				sym_count_n = '0;
			end
		end else if (rise_seen && (is_dash || is_dot) && room) begin
			sym_bits_n  = sym_bits | (MAX_SYMBOLS'(is_dash) << sym_count);
			sym_count_n = sym_count + CNTW'(1);
		end
	end

endmodule

`default_nettype wire
